@@ rtl/erad_pkg.sv @@
// ----------------------------------------------------------------------------
// erad_pkg
// Shared types, codes and reset constants of the edge rate activity detector.
// ----------------------------------------------------------------------------
package erad_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int MAX_EDGES_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 31;
  localparam int THRESH_W = 5;
  localparam int EDGES_W  = 5;
  localparam int CHAN_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 31'd1000;
  localparam logic [THRESH_W-1:0] THRESH_RST = 5'd3;
  localparam logic [EDGES_W-1:0]  EDGES_MAX  = 5'd31;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 4'd1;

  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] now_ms;
  } erad_in_t;

  typedef struct packed {
    logic [EDGES_W-1:0] edges_in_window;
    logic               active;
  } erad_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } erad_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } erad_state_t;

endpackage

@@ rtl/erad_store.sv @@
// ----------------------------------------------------------------------------
// erad_store
// Timestamp memory with per-channel ring write index and saturating fill count.
// ----------------------------------------------------------------------------
module erad_store import erad_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int CNT_W  = $clog2(MAX_EDGES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  erad_mem_ctl_t       ctl,
  input  logic [CH_W-1:0]     wr_ch,
  input  logic [TIME_W-1:0]   wr_time,
  input  logic [CH_W-1:0]     rd_ch,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [TIME_W-1:0]   rd_data,
  input  logic [CH_W-1:0]     fill_ch,
  output logic [CNT_W-1:0]    fill
);

  localparam int DEPTH  = CHANNELS * MAX_EDGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  wr_idx_r [CHANNELS];
  logic [CNT_W-1:0]  fill_r   [CHANNELS];
  logic [IDX_W-1:0]  wr_idx_nxt;
  logic [CNT_W-1:0]  fill_nxt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(32'(wr_ch) * 32'(MAX_EDGES) + 32'(wr_idx_r[wr_ch]));
  assign rd_addr = ADDR_W'(32'(rd_ch) * 32'(MAX_EDGES) + 32'(rd_idx));

  always_comb begin
    if (wr_idx_r[wr_ch] == IDX_W'(MAX_EDGES - 1)) begin
      wr_idx_nxt = '0;
    end else begin
      wr_idx_nxt = wr_idx_r[wr_ch] + IDX_W'(1);
    end
    if (fill_r[wr_ch] == CNT_W'(MAX_EDGES)) begin
      fill_nxt = fill_r[wr_ch];
    end else begin
      fill_nxt = fill_r[wr_ch] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_time;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_idx_r[c] <= '0;
        fill_r[c]   <= '0;
      end
    end else if (ctl.wr_en) begin
      wr_idx_r[wr_ch] <= wr_idx_nxt;
      fill_r[wr_ch]   <= fill_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign fill    = fill_r[fill_ch];

endmodule

@@ rtl/erad_age_cmp.sv @@
// ----------------------------------------------------------------------------
// erad_age_cmp
// Shared age unit: wrapping age of a stored edge checked against the window.
// ----------------------------------------------------------------------------
module erad_age_cmp import erad_pkg::*; (
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [TIME_W-1:0]   stamp,
  input  logic [WINDOW_W-1:0] window_ms,
  output logic                hit
);

  logic [TIME_W-1:0] age;

  assign age = now_ms - stamp;
  assign hit = (age <= {1'b0, window_ms});

endmodule

@@ rtl/erad_seq.sv @@
// ----------------------------------------------------------------------------
// erad_seq
// Item sequencer: takes records and queries, walks the channel's stored edges
// through the shared age unit and counts hits.
// ----------------------------------------------------------------------------
module erad_seq import erad_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF,
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int CNT_W  = $clog2(MAX_EDGES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  erad_in_t            in_data,
  input  logic [WINDOW_W-1:0] window_ms,
  output erad_mem_ctl_t       mem_ctl,
  output logic [CH_W-1:0]     wr_ch,
  output logic [TIME_W-1:0]   wr_time,
  output logic [CH_W-1:0]     rd_ch,
  output logic [IDX_W-1:0]    rd_idx,
  input  logic [TIME_W-1:0]   rd_data,
  output logic [CH_W-1:0]     fill_ch,
  input  logic [CNT_W-1:0]    fill,
  output logic                res_valid,
  input  logic                res_take,
  output logic [CNT_W-1:0]    res_cnt
);

  erad_state_t       state_r, state_nxt;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              ch_ok;
  logic              hit;

  assign ch_ok   = (32'(in_data.channel) < 32'(CHANNELS));
  assign wr_ch   = CH_W'(in_data.channel);
  assign wr_time = in_data.now_ms;
  assign fill_ch = CH_W'(in_data.channel);
  assign rd_ch   = ch_r;
  assign rd_idx  = i_r;
  assign res_cnt = cnt_r;

  erad_age_cmp u_cmp (
    .now_ms    (now_r),
    .stamp     (rd_data),
    .window_ms (window_ms),
    .hit       (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    ch_nxt        = ch_r;
    now_nxt       = now_r;
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    if (cmp_vld_r && hit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.op == OP_RECORD) begin
            mem_ctl.wr_en = ch_ok;
          end else begin
            i_nxt   = '0;
            cnt_nxt = '0;
            ch_nxt  = CH_W'(in_data.channel);
            now_nxt = in_data.now_ms;
            if (ch_ok && (fill != '0)) begin
              fill_nxt  = fill;
              state_nxt = ST_SCAN;
            end else begin
              fill_nxt  = '0;
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        i_nxt         = i_r + IDX_W'(1);
        if (CNT_W'(i_r) + CNT_W'(1) == fill_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= mem_ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    cnt_r  <= cnt_nxt;
    fill_r <= fill_nxt;
    ch_r   <= ch_nxt;
    now_r  <= now_nxt;
  end

`ifndef ASSERT_OFF
  a_drain_has_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> cmp_vld_r)
    else $error("drain state without a pending compare");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r <= fill_r))
    else $error("hit count exceeds stored edges");

  a_no_read_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> !cmp_vld_r)
    else $error("compare pending after idle cycle");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_take) |=> (state_r == ST_IDLE))
    else $error("result taken but sequencer not released");
`endif

endmodule

@@ rtl/edge_rate_activity_detector.sv @@
// ----------------------------------------------------------------------------
// edge_rate_activity_detector
// Per-channel edge activity detector over a sliding time window.
//
// Input channel (in_valid / in_stall / in_data) carries records and queries.
// A record stores now_ms as an edge of its channel, overwriting the oldest
// entry once the ring of MAX_EDGES entries is full, and gives no result.
// A record leaves the sequencer idle. A query with fill stored edges (at most
// MAX_EDGES) runs ST_SCAN, ST_DRAIN, ST_DONE and returns to ST_IDLE for the
// next item; an empty channel goes straight to ST_DONE. One memory read port
// feeds one age comparator, one stored edge per cycle; in_stall is high.
// Result channel (out_valid / out_stall / out_data) gives edges_in_window,
// saturated at 31, and active. The output register holds a finished result
// while the receiver stalls; the next item is still taken meanwhile and a
// later query waits in its final state until the register frees up.
// cfg_ready is always high; write registers only while the block is idle.
// Reset clears ring indexes, fill counts and the sequencer, and loads the
// register defaults. The timestamp memory is not cleared: only entries
// below a channel's fill count are ever read.
// ----------------------------------------------------------------------------
module edge_rate_activity_detector import erad_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  erad_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output erad_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  logic [WINDOW_W-1:0] window_r;
  logic [THRESH_W-1:0] thresh_r;
  logic                out_valid_r;
  erad_out_t           out_data_r, out_data_nxt;

  erad_mem_ctl_t       mem_ctl;
  logic [CH_W-1:0]     wr_ch;
  logic [TIME_W-1:0]   wr_time;
  logic [CH_W-1:0]     rd_ch;
  logic [IDX_W-1:0]    rd_idx;
  logic [TIME_W-1:0]   rd_data;
  logic [CH_W-1:0]     fill_ch;
  logic [CNT_W-1:0]    fill;
  logic                res_valid;
  logic                res_take;
  logic [CNT_W-1:0]    res_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW: window_r <= cfg_data[WINDOW_W-1:0];
        CFG_THRESH: thresh_r <= cfg_data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  erad_store #(
    .CHANNELS  (CHANNELS),
    .MAX_EDGES (MAX_EDGES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_ch   (wr_ch),
    .wr_time (wr_time),
    .rd_ch   (rd_ch),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .fill_ch (fill_ch),
    .fill    (fill)
  );

  erad_seq #(
    .CHANNELS  (CHANNELS),
    .MAX_EDGES (MAX_EDGES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .window_ms (window_r),
    .mem_ctl   (mem_ctl),
    .wr_ch     (wr_ch),
    .wr_time   (wr_time),
    .rd_ch     (rd_ch),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .fill_ch   (fill_ch),
    .fill      (fill),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_cnt   (res_cnt)
  );

  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    if (32'(res_cnt) > 32'(EDGES_MAX)) begin
      out_data_nxt.edges_in_window = EDGES_MAX;
    end else begin
      out_data_nxt.edges_in_window = EDGES_W'(res_cnt);
    end
    out_data_nxt.active = (32'(res_cnt) >= 32'(thresh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
